FILE: hw/rtl/i2a_pkg.sv
// Shared types and constants for the integer to ASCII formatter.
package i2a_pkg;

  localparam logic [1:0] OP_SDEC = 2'd0;
  localparam logic [1:0] OP_UDEC = 2'd1;
  localparam logic [1:0] OP_LHEX = 2'd2;
  localparam logic [1:0] OP_UHEX = 2'd3;

  localparam logic [6:0] CH_SPACE   = 7'h20;
  localparam logic [6:0] CH_PLUS    = 7'h2B;
  localparam logic [6:0] CH_MINUS   = 7'h2D;
  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_UX      = 7'h58;
  localparam logic [6:0] CH_LX      = 7'h78;
  localparam logic [6:0] CH_UA_BASE = 7'h37;
  localparam logic [6:0] CH_LA_BASE = 7'h57;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
    logic        left_align;
    logic        plus_sign;
    logic        space_sign;
    logic        hex_prefix;
    logic        zero_pad;
    logic [5:0]  field_width;
  } i2a_in_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } i2a_out_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic norm;
    logic emit;
  } i2a_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic norm_done;
    logic out_free;
    logic last_char;
  } i2a_sts_t;

endpackage

FILE: hw/rtl/i2a_ctrl.sv
// Controller state machine that sequences load, conversion, normalization and emission.
module i2a_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2a_pkg::i2a_sts_t  sts,
  output i2a_pkg::i2a_cmd_t  cmd
);
  import i2a_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_NORM = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd.load = in_ready && in_valid;
    cmd.conv = (state_r == ST_CONV) && !sts.conv_done;
    cmd.norm = (state_r == ST_NORM) && !sts.norm_done;
    cmd.emit = (state_r == ST_EMIT) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (sts.conv_done) state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (sts.norm_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.last_char) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The final character of a transaction always returns the controller to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && sts.last_char |=> state_r == ST_IDLE)
    else $error("controller did not return to idle after the last character");

endmodule

FILE: hw/rtl/i2a_datapath.sv
// Datapath with the binary to BCD converter, digit register and output register.
module i2a_datapath #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_WIDTH  = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  input  i2a_pkg::i2a_in_t   in_data,
  input  i2a_pkg::i2a_cmd_t  cmd,
  input  logic               out_ready,
  output i2a_pkg::i2a_sts_t  sts,
  output logic               out_valid,
  output i2a_pkg::i2a_out_t  out_data
);
  import i2a_pkg::*;

  localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W = 4 * NDIG;
  localparam int ND_W  = $clog2(NDIG + 1);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [ND_W-1:0]       nd_r, nd_nxt;
  logic [1:0]            nl_r;
  logic [6:0]            lead0_r, lead1_r;
  logic                  upper_r, left_r, zero_r;
  logic [5:0]            width_r;
  logic [5:0]            idx_r;
  logic                  out_valid_r;
  i2a_out_t              out_r;

  logic [VALUE_BITS-1:0] v_in, mag_ld;
  logic                  in_hex, in_upper, in_neg;
  logic [BCD_W-1:0]      bcd_adj;
  logic [3:0]            top_dig;
  logic [5:0]            content, pad, pre, zp, b1, b2, b3, b4, total;
  logic                  in_digit;
  logic [6:0]            dig_char, ch;

  assign v_in     = in_data.value[VALUE_BITS-1:0];
  assign in_hex   = (in_data.op == OP_LHEX) || (in_data.op == OP_UHEX);
  assign in_upper = (in_data.op == OP_UHEX);
  assign in_neg   = (in_data.op == OP_SDEC) && v_in[VALUE_BITS-1];
  assign mag_ld   = in_neg ? (~v_in + VALUE_BITS'(1)) : v_in;
  assign top_dig  = bcd_r[BCD_W-1 -: 4];

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      bcd_adj[4*k +: 4] = (bcd_r[4*k +: 4] >= 4'd5) ? bcd_r[4*k +: 4] + 4'd3
                                                      : bcd_r[4*k +: 4];
    end
  end

  assign content = 6'(nd_r) + {4'b0, nl_r};
  assign pad     = (width_r > content) ? (width_r - content) : 6'd0;
  assign total   = content + pad;
  assign pre     = (!left_r && !zero_r) ? pad : 6'd0;
  assign zp      = (!left_r && zero_r) ? pad : 6'd0;
  assign b1      = pre;
  assign b2      = b1 + {4'b0, nl_r};
  assign b3      = b2 + zp;
  assign b4      = b3 + 6'(nd_r);
  assign in_digit = (idx_r >= b3) && (idx_r < b4);

  assign dig_char = (top_dig < 4'd10) ? CH_ZERO + {3'b0, top_dig}
                  : (upper_r ? CH_UA_BASE : CH_LA_BASE) + {3'b0, top_dig};

  always_comb begin
    if (idx_r < b1) begin
      ch = CH_SPACE;
    end else if (idx_r < b2) begin
      ch = (idx_r == b1) ? lead0_r : lead1_r;
    end else if (idx_r < b3) begin
      ch = CH_ZERO;
    end else if (in_digit) begin
      ch = dig_char;
    end else begin
      ch = CH_SPACE;
    end
  end

  always_comb begin
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    nd_nxt  = nd_r;
    if (cmd.load) begin
      mag_nxt = mag_ld;
      cnt_nxt = in_hex ? '0 : CNT_W'(VALUE_BITS);
      bcd_nxt = in_hex ? {{(BCD_W-VALUE_BITS){1'b0}}, mag_ld} : '0;
      nd_nxt  = ND_W'(NDIG);
    end else if (cmd.conv) begin
      mag_nxt = {mag_r[VALUE_BITS-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
      cnt_nxt = cnt_r - CNT_W'(1);
    end else if (cmd.norm) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'h0};
      nd_nxt  = nd_r - ND_W'(1);
    end else if (cmd.emit && in_digit) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'h0};
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    nd_r  <= nd_nxt;
    if (cmd.load) begin
      upper_r <= in_upper;
      left_r  <= in_data.left_align;
      zero_r  <= in_data.zero_pad;
      width_r <= (in_data.field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH)
                                                      : in_data.field_width;
      lead1_r <= in_upper ? CH_UX : CH_LX;
      if (in_hex) begin
        lead0_r <= CH_ZERO;
        nl_r    <= in_data.hex_prefix ? 2'd2 : 2'd0;
      end else begin
        lead0_r <= in_neg ? CH_MINUS : (in_data.plus_sign ? CH_PLUS : CH_SPACE);
        nl_r    <= (in_neg || in_data.plus_sign || in_data.space_sign) ? 2'd1 : 2'd0;
      end
      idx_r <= 6'd0;
    end else if (cmd.emit) begin
      idx_r <= idx_r + 6'd1;
    end
    if (cmd.emit) begin
      out_r.character <= ch;
      out_r.last      <= (idx_r == total - 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.conv_done = (cnt_r == '0);
    sts.norm_done = (nd_r == ND_W'(1)) || (top_dig != 4'h0);
    sts.out_free  = !out_valid_r || out_ready;
    sts.last_char = (idx_r == total - 6'd1);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.conv |-> cnt_r != '0)
    else $error("conversion step issued with no bits left");

  a_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.norm |-> (top_dig == 4'h0) && (nd_r > ND_W'(1)))
    else $error("normalization dropped a significant digit");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> idx_r < total)
    else $error("character emitted beyond the field length");

endmodule

FILE: hw/rtl/integer_to_ascii_formatter.sv
// Top level of the printf-style integer to ASCII formatter.
// The first character follows a bit-serial binary to BCD conversion for decimal (hex loads
// its digits directly), then normalization, which drops the leading zero digits (at most 19).
// Throughput: one character per cycle while the output is not stalled; a transaction yields
// max(width, content) characters, and the next one is accepted only after the last is issued.
// Reset (synchronous, active low) clears the state machine and output valid.
module integer_to_ascii_formatter #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_WIDTH  = 63
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2a_pkg::i2a_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output i2a_pkg::i2a_out_t out_data
);
  import i2a_pkg::*;

  i2a_cmd_t cmd;
  i2a_sts_t sts;

  i2a_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  i2a_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the printf-style integer to ASCII formatter.
`timescale 1ns / 100ps

module tb_top;
  import i2a_pkg::*;

  localparam int VALUE_BITS = 64;
  localparam int MAX_WIDTH  = 63;

  localparam logic [4:0] FL_NONE   = 5'b00000;
  localparam logic [4:0] FL_LEFT   = 5'b10000;
  localparam logic [4:0] FL_PLUS   = 5'b01000;
  localparam logic [4:0] FL_SPACE  = 5'b00100;
  localparam logic [4:0] FL_PREFIX = 5'b00010;
  localparam logic [4:0] FL_ZERO   = 5'b00001;

  localparam logic [63:0] V_MIN_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] V_MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] V_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    i2a_in_t item;
    string   text;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  i2a_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  i2a_out_t out_data;

  i2a_out_t pending_chars[$];
  i2a_out_t want_char;
  int       mismatch_count = 0;
  int       send_idle_pct  = 0;
  int       recv_idle_pct  = 0;
  bit       hold_off_req   = 0;

  integer_to_ascii_formatter #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic i2a_in_t make_item(input logic [1:0] op, input logic [63:0] value,
                                        input logic [4:0] flags, input logic [5:0] width);
    i2a_in_t it;
    it.op          = op;
    it.value       = value;
    it.left_align  = flags[4];
    it.plus_sign   = flags[3];
    it.space_sign  = flags[2];
    it.hex_prefix  = flags[1];
    it.zero_pad    = flags[0];
    it.field_width = width;
    return it;
  endfunction

  // Builds the formatted field for one transaction and queues its characters.
  function automatic void predict_field(input i2a_in_t it);
    logic [63:0] mag;
    logic [6:0]  digit_chars[$];
    logic [6:0]  lead_chars[$];
    logic [6:0]  field_chars[$];
    bit          is_hex;
    bit          is_upper;
    bit          is_neg;
    int          dgt;
    int          fw;
    int          pad;
    is_hex   = (it.op == OP_LHEX) || (it.op == OP_UHEX);
    is_upper = (it.op == OP_UHEX);
    mag      = it.value;
    is_neg   = (it.op == OP_SDEC) && mag[VALUE_BITS-1];
    if (is_neg) begin
      mag = -mag;
    end
    do begin
      if (is_hex) begin
        dgt = int'(mag[3:0]);
        mag = mag >> 4;
      end else begin
        dgt = int'(mag % 64'd10);
        mag = mag / 64'd10;
      end
      if (dgt < 10) begin
        digit_chars.push_front(CH_ZERO + 7'(dgt));
      end else begin
        digit_chars.push_front((is_upper ? CH_UA_BASE : CH_LA_BASE) + 7'(dgt));
      end
    end while (mag != 64'd0);
    if (is_hex) begin
      if (it.hex_prefix) begin
        lead_chars.push_back(CH_ZERO);
        lead_chars.push_back(is_upper ? CH_UX : CH_LX);
      end
    end else if (is_neg) begin
      lead_chars.push_back(CH_MINUS);
    end else if (it.plus_sign) begin
      lead_chars.push_back(CH_PLUS);
    end else if (it.space_sign) begin
      lead_chars.push_back(CH_SPACE);
    end
    fw = int'(it.field_width);
    if (fw > MAX_WIDTH) begin
      fw = MAX_WIDTH;
    end
    pad = fw - digit_chars.size() - lead_chars.size();
    if (pad < 0) begin
      pad = 0;
    end
    if (!it.left_align && !it.zero_pad) begin
      repeat (pad) field_chars.push_back(CH_SPACE);
    end
    foreach (lead_chars[i]) field_chars.push_back(lead_chars[i]);
    if (!it.left_align && it.zero_pad) begin
      repeat (pad) field_chars.push_back(CH_ZERO);
    end
    foreach (digit_chars[i]) field_chars.push_back(digit_chars[i]);
    if (it.left_align) begin
      repeat (pad) field_chars.push_back(CH_SPACE);
    end
    foreach (field_chars[i]) begin
      pending_chars.push_back('{character: field_chars[i],
                                last: (i == field_chars.size() - 1)});
    end
  endfunction

  function automatic i2a_in_t random_item();
    i2a_in_t     it;
    logic [63:0] value;
    logic [5:0]  width;
    case ($urandom_range(9))
      0, 1, 2, 3: value = {$urandom, $urandom};
      4, 5:       value = 64'($urandom_range(999));
      6, 7:       value = {$urandom, $urandom} >> $urandom_range(63);
      8:          value = -64'($urandom_range(1000));
      default: begin
        case ($urandom_range(3))
          0:       value = 64'd0;
          1:       value = V_MIN_NEG;
          2:       value = V_MAX_POS;
          default: value = V_ONES;
        endcase
      end
    endcase
    if ($urandom_range(99) < 80) begin
      width = 6'($urandom_range(24));
    end else begin
      width = 6'($urandom_range(63));
    end
    it = make_item(2'($urandom_range(3)), value, 5'($urandom), width);
    return it;
  endfunction

  // Offers one transaction and records its expected characters on acceptance.
  task automatic send_item(input i2a_in_t it, input string text);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (text.len() == 0) begin
      predict_field(it);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        pending_chars.push_back('{character: 7'(text[i]), last: (i == text.len() - 1)});
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected transaction: character %h, last %b",
               out_data.character, out_data.last);
        mismatch_count++;
      end else begin
        want_char = pending_chars.pop_front();
        if (out_data.character !== want_char.character) begin
          $error("character: expected %h, got %h", want_char.character, out_data.character);
          mismatch_count++;
        end
        if (out_data.last !== want_char.last) begin
          $error("last: expected %b, got %b", want_char.last, out_data.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    dir_row_t directed_rows[$];
    int       send_pct[3];
    int       recv_pct[3];
    send_pct = '{17, 87, 0};
    recv_pct = '{87, 17, 0};
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    directed_rows.push_back('{make_item(OP_SDEC, 64'd0, FL_NONE, 6'd0), "0"});
    directed_rows.push_back('{make_item(OP_SDEC, V_MIN_NEG, FL_NONE, 6'd0),
                              "-9223372036854775808"});
    directed_rows.push_back('{make_item(OP_UDEC, V_ONES, FL_NONE, 6'd0),
                              "18446744073709551615"});
    directed_rows.push_back('{make_item(OP_LHEX, V_ONES, FL_PREFIX, 6'd0),
                              "0xffffffffffffffff"});
    directed_rows.push_back('{make_item(OP_UHEX, 64'd0, FL_PREFIX, 6'd0), "0X0"});
    directed_rows.push_back('{make_item(OP_SDEC, 64'd42, FL_PLUS, 6'd6), "   +42"});
    directed_rows.push_back('{make_item(OP_SDEC, 64'd42, FL_SPACE, 6'd0), " 42"});
    directed_rows.push_back('{make_item(OP_SDEC, 64'd42, FL_PLUS | FL_SPACE, 6'd0), "+42"});
    directed_rows.push_back('{make_item(OP_SDEC, -64'd42, FL_ZERO, 6'd6), "-00042"});
    directed_rows.push_back('{make_item(OP_SDEC, 64'd42, FL_LEFT | FL_PLUS, 6'd6), "+42   "});
    directed_rows.push_back('{make_item(OP_SDEC, 64'd42, FL_LEFT | FL_ZERO, 6'd5), "42   "});
    directed_rows.push_back('{make_item(OP_LHEX, 64'd255, FL_PLUS | FL_SPACE, 6'd0), "ff"});
    directed_rows.push_back('{make_item(OP_UDEC, 64'd7, FL_PREFIX, 6'd0), "7"});
    directed_rows.push_back('{make_item(OP_UDEC, 64'd5, FL_PLUS, 6'd3), " +5"});
    directed_rows.push_back('{make_item(OP_UHEX, 64'hABC, FL_PREFIX | FL_ZERO, 6'd8),
                              "0X000ABC"});
    directed_rows.push_back('{make_item(OP_SDEC, -64'd1, FL_NONE, 6'd0), "-1"});
    directed_rows.push_back('{make_item(OP_UDEC, 64'd123, FL_NONE, 6'd2), "123"});
    directed_rows.push_back('{make_item(OP_LHEX, 64'hDEAD_BEEF, FL_NONE, 6'd0), "deadbeef"});
    directed_rows.push_back('{make_item(OP_UHEX, 64'd0, FL_NONE, 6'd1), "0"});
    directed_rows.push_back('{make_item(OP_SDEC, 64'd1, FL_NONE, 6'd63), ""});
    directed_rows.push_back('{make_item(OP_LHEX, 64'd1, FL_LEFT | FL_PREFIX, 6'd63), ""});
    directed_rows.push_back('{make_item(OP_SDEC, V_MAX_POS, FL_ZERO, 6'd63), ""});
    directed_rows.push_back('{make_item(OP_SDEC, V_MIN_NEG, FL_ZERO, 6'd25), ""});
    directed_rows.push_back('{make_item(OP_SDEC, 64'd1, 5'b11111, 6'd63), ""});
    directed_rows.push_back('{make_item(OP_UHEX, V_MIN_NEG, 5'b11111, 6'd40), ""});

    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];
    foreach (directed_rows[i]) send_item(directed_rows[i].item, directed_rows[i].text);
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      for (int n = 0; n < 112; n++) begin
        if (ph == 0 && n == 10) begin
          hold_off_req = 1'b1;
        end
        send_item(random_item(), "");
      end
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: integer_to_ascii_formatter.f
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_ctrl.sv
hw/rtl/i2a_datapath.sv
hw/rtl/integer_to_ascii_formatter.sv
tb/sv/tb_top.sv
